/* hdl/hptd_pkg.sv */
// ----------------------------------------------------------------------------
// hptd_pkg
// Shared types and constants for the preorder-tree stream decoder.
// ----------------------------------------------------------------------------
package hptd_pkg;

    localparam int DEF_MAX_INTERNAL_NODES = 255;
    localparam int DEF_COUNT_FIELD_BITS   = 32;
    localparam int DEF_SYMBOL_BITS        = 8;

    localparam int SYM_W   = 8;
    localparam int COUNT_W = 32;
    localparam int IDX_W   = 8;
    localparam int CHILD_W = 9;

    // Decoding phases
    localparam logic [1:0] PH_TREE    = 2'd0;
    localparam logic [1:0] PH_COUNT   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic [COUNT_W-1:0] rep;
        logic               done;
        logic               bad;
    } result_t;

    typedef struct packed {
        logic load;
        logic step_bit;
        logic step_use;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       last_bit;
        logic       bits_done;
        logic       pend_valid;
        logic       out_free;
    } sts_t;

endpackage

/* hdl/hptd_ctrl.sv */
// ----------------------------------------------------------------------------
// hptd_ctrl
// Sequencer: walks the bits of each accepted byte and drains results.
// ----------------------------------------------------------------------------
module hptd_ctrl
    import hptd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BIT   = 2'd1;
    localparam logic [1:0] ST_USE   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decide the next step
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (sts.phase == PH_HALT)
                    state_next = ST_FLUSH;
                else if (sts.out_free)
                begin
                    cmd.step_bit = 1'b1;
                    if (sts.phase == PH_PAYLOAD)
                        state_next = ST_USE;
                    else if (sts.last_bit)
                        state_next = ST_FLUSH;
                end
            end
            ST_USE:
            begin
                if (sts.out_free)
                begin
                    cmd.step_use = 1'b1;
                    state_next   = sts.bits_done ? ST_FLUSH : ST_BIT;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    a_use_after_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_USE) |-> $past(state_reg == ST_BIT || state_reg == ST_USE))
        else $error("walk step without a preceding bit step");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_BIT))
        else $error("load did not start bit processing");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step_bit, cmd.step_use, cmd.flush}))
        else $error("more than one command issued");
`endif

endmodule

/* hdl/hptd_datapath.sv */
// ----------------------------------------------------------------------------
// hptd_datapath
// Header parser, count assembler, tree walker and result staging.
// ----------------------------------------------------------------------------
module hptd_datapath
    import hptd_pkg::*;
#(
    parameter int MAX_INTERNAL_NODES = DEF_MAX_INTERNAL_NODES,
    parameter int COUNT_FIELD_BITS   = DEF_COUNT_FIELD_BITS,
    parameter int SYMBOL_BITS        = DEF_SYMBOL_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic [7:0]    in_byte,
    output sts_t          sts,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_res,
    output logic          out_last
);

    localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << SYMBOL_BITS) - 1);
    localparam logic [IDX_W-1:0] MAX_NODES = IDX_W'(MAX_INTERNAL_NODES);
    localparam logic [5:0]       CNT_BITS  = 6'(COUNT_FIELD_BITS);

    // Node and stack memories
    logic [CHILD_W-1:0] left_mem  [MAX_INTERNAL_NODES];
    logic [CHILD_W-1:0] right_mem [MAX_INTERNAL_NODES];
    logic [IDX_W:0]     stack_mem [MAX_INTERNAL_NODES];
    logic [CHILD_W-1:0] left_q, right_q;
    logic [IDX_W:0]     stack_q;

    logic               left_we, right_we, stack_we;
    logic [IDX_W-1:0]   node_waddr, stack_waddr;
    logic [CHILD_W-1:0] node_wdata;
    logic [IDX_W:0]     stack_wdata;

    logic [1:0]         phase_reg, phase_next;
    logic [7:0]         byte_reg, byte_next;
    logic [3:0]         bits_reg, bits_next;
    logic               b_reg, b_next;
    logic [SYM_W-1:0]   sym_shift_reg, sym_shift_next;
    logic [3:0]         sym_cnt_reg, sym_cnt_next;
    logic [COUNT_W-1:0] cnt_shift_reg, cnt_shift_next;
    logic [5:0]         cnt_bits_reg, cnt_bits_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0]   nfn_reg, nfn_next;
    logic [IDX_W-1:0]   depth_reg, depth_next;
    logic [IDX_W-1:0]   top_node_reg, top_node_next;
    logic               top_flag_reg, top_flag_next;
    logic [CHILD_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0]   walk_reg, walk_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    logic               bit_in;
    logic               emit;
    result_t            emit_res;
    logic               att;
    logic               att_push;
    logic [CHILD_W-1:0] att_child;
    logic [SYM_W-1:0]   sym_new;
    logic [COUNT_W-1:0] cnt_new;
    logic [CHILD_W-1:0] walk_child;
    logic               pop;

    assign bit_in  = byte_reg[7];
    assign sym_new = {sym_shift_reg[SYM_W-2:0], bit_in} & SYM_MASK;
    assign cnt_new = {cnt_shift_reg[COUNT_W-2:0], bit_in};
    assign walk_child = b_reg ? right_q : left_q;

    assign sts.phase      = phase_reg;
    assign sts.last_bit   = (bits_reg == 4'd1);
    assign sts.bits_done  = (bits_reg == 4'd0);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

    // Header, count and walk steps
    always_comb
    begin
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        bits_next      = bits_reg;
        b_next         = b_reg;
        sym_shift_next = sym_shift_reg;
        sym_cnt_next   = sym_cnt_reg;
        cnt_shift_next = cnt_shift_reg;
        cnt_bits_next  = cnt_bits_reg;
        left_next      = left_reg;
        nfn_next       = nfn_reg;
        walk_next      = walk_reg;
        root_next      = root_reg;
        emit           = 1'b0;
        emit_res       = '0;
        att            = 1'b0;
        att_push       = 1'b0;
        att_child      = '0;

        if (cmd.load)
        begin
            byte_next = in_byte;
            bits_next = 4'd8;
        end

        if (cmd.step_bit)
        begin
            byte_next = {byte_reg[6:0], 1'b0};
            bits_next = bits_reg - 4'd1;
            b_next    = bit_in;
            unique case (phase_reg)
                PH_TREE:
                begin
                    if (sym_cnt_reg != 4'd0)
                    begin
                        sym_shift_next = sym_new;
                        sym_cnt_next   = sym_cnt_reg - 4'd1;
                        if (sym_cnt_reg == 4'd1)
                        begin
                            att       = 1'b1;
                            att_child = {1'b1, sym_new};
                        end
                    end
                    else if (bit_in)
                    begin
                        sym_cnt_next   = 4'(SYMBOL_BITS);
                        sym_shift_next = '0;
                    end
                    else if (nfn_reg >= MAX_NODES)
                    begin
                        emit         = 1'b1;
                        emit_res.bad = 1'b1;
                        phase_next   = PH_HALT;
                    end
                    else
                    begin
                        nfn_next  = nfn_reg + 1'b1;
                        att       = 1'b1;
                        att_push  = 1'b1;
                        att_child = {1'b0, nfn_reg};
                    end
                end
                PH_COUNT:
                begin
                    cnt_shift_next = cnt_new;
                    cnt_bits_next  = cnt_bits_reg + 6'd1;
                    if (cnt_bits_reg + 6'd1 == CNT_BITS)
                    begin
                        cnt_shift_next = '0;
                        cnt_bits_next  = '0;
                        walk_next      = '0;
                        left_next      = cnt_new;
                        if (cnt_new == '0)
                            phase_next = PH_HALT;
                        else if (root_reg[CHILD_W-1])
                        begin
                            emit          = 1'b1;
                            emit_res.sym  = root_reg[SYM_W-1:0];
                            emit_res.rep  = cnt_new;
                            emit_res.done = 1'b1;
                            left_next     = '0;
                            phase_next    = PH_HALT;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: ;
                PH_HALT: ;
                default: ;
            endcase
        end

        // Walk one edge of the tree
        if (cmd.step_use)
        begin
            if (walk_child[CHILD_W-1])
            begin
                left_next     = left_reg - 1'b1;
                walk_next     = '0;
                emit          = 1'b1;
                emit_res.sym  = walk_child[SYM_W-1:0];
                emit_res.rep  = 32'd1;
                emit_res.done = (left_reg == 32'd1);
                if (left_reg == 32'd1)
                    phase_next = PH_HALT;
            end
            else
                walk_next = walk_child[IDX_W-1:0];
        end

        // Hang a new child in the tree
        pop           = 1'b0;
        depth_next    = depth_reg;
        top_node_next = top_node_reg;
        top_flag_next = top_flag_reg;
        left_we       = 1'b0;
        right_we      = 1'b0;
        stack_we      = 1'b0;
        node_waddr    = top_node_reg;
        node_wdata    = att_child;
        stack_waddr   = depth_reg - 1'b1;
        stack_wdata   = {1'b1, top_node_reg};
        if (att)
        begin
            if (depth_reg == '0)
            begin
                root_next = att_child;
                if (att_child[CHILD_W-1])
                    phase_next = PH_COUNT;
            end
            else if (!top_flag_reg)
            begin
                left_we       = 1'b1;
                top_flag_next = 1'b1;
            end
            else
            begin
                right_we      = 1'b1;
                pop           = 1'b1;
                top_node_next = stack_q[IDX_W-1:0];
                top_flag_next = stack_q[IDX_W];
                depth_next    = depth_reg - 1'b1;
                if (depth_reg == 8'd1 && att_child[CHILD_W-1])
                    phase_next = PH_COUNT;
            end
            if (att_push)
            begin
                top_node_next = att_child[IDX_W-1:0];
                top_flag_next = 1'b0;
                if (depth_reg == '0)
                    depth_next = 8'd1;
                else if (!pop)
                begin
                    stack_we   = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
                else
                    depth_next = depth_reg;
            end
        end
    end

    // Stage results: the newest waits until the next one or the byte end
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TREE;
            bits_reg       <= '0;
            sym_cnt_reg    <= '0;
            cnt_bits_reg   <= '0;
            cnt_shift_reg  <= '0;
            sym_shift_reg  <= '0;
            left_reg       <= '0;
            nfn_reg        <= '0;
            depth_reg      <= '0;
            top_flag_reg   <= 1'b0;
            root_reg       <= '0;
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bits_reg       <= bits_next;
            sym_cnt_reg    <= sym_cnt_next;
            cnt_bits_reg   <= cnt_bits_next;
            cnt_shift_reg  <= cnt_shift_next;
            sym_shift_reg  <= sym_shift_next;
            left_reg       <= left_next;
            nfn_reg        <= nfn_next;
            depth_reg      <= depth_next;
            top_flag_reg   <= top_flag_next;
            root_reg       <= root_next;
            walk_reg       <= walk_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        b_reg        <= b_next;
        top_node_reg <= top_node_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Memories: one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (left_we)
            left_mem[node_waddr] <= node_wdata;
        if (right_we)
            right_mem[node_waddr] <= node_wdata;
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        left_q  <= left_mem[walk_reg];
        right_q <= right_mem[walk_reg];
        stack_q <= stack_mem[depth_reg - 8'd2];
    end

`ifndef NO_ASSERTIONS
    a_depth_le_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= nfn_reg)
        else $error("parse stack deeper than node count");
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |=> (phase_reg == PH_HALT))
        else $error("left halted phase");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.bad) |-> (out_reg.rep == '0 && out_reg.sym == '0))
        else $error("malformed result carries data");
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("pending result survived a flush");
`endif

endmodule

/* hdl/huffman_preorder_tree_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_preorder_tree_decoder
// Decodes a byte stream holding a preorder code tree, a symbol count and
// the coded payload.
// ----------------------------------------------------------------------------
// One byte is taken per transfer and its bits are used MSB first. Header and
// count bits take one bit step each; payload bits take a bit step and then a
// walk step, since each edge of the walk waits on a registered read of the
// node table. A byte is loaded, its bits are stepped and a flush step closes
// it before the next transfer; steps wait while the master side holds a
// result. Once halted, a byte is loaded and flushed without using its bits.
// Results of a byte are staged one behind, so the last one of a byte goes out
// when the byte is finished and carries tlast. A malformed header (too many
// internal nodes) gives one result with tuser[1] set and the decoder halts
// until reset; so does the completion of the symbol count.
module huffman_preorder_tree_decoder
    import hptd_pkg::*;
#(
    parameter int MAX_INTERNAL_NODES = DEF_MAX_INTERNAL_NODES,
    parameter int COUNT_FIELD_BITS   = DEF_COUNT_FIELD_BITS,
    parameter int SYMBOL_BITS        = DEF_SYMBOL_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] symbol, [39:8] repeat_count
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] message_done, [1] malformed
);

    cmd_t    cmd;
    sts_t    sts;
    result_t res;

    hptd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hptd_datapath
    #(
        .MAX_INTERNAL_NODES (MAX_INTERNAL_NODES),
        .COUNT_FIELD_BITS   (COUNT_FIELD_BITS),
        .SYMBOL_BITS        (SYMBOL_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_byte   (s_tdata),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {res.rep, res.sym};
    assign m_tuser = {res.bad, res.done};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the preorder-tree stream decoder.
// ----------------------------------------------------------------------------
// One compressed message is streamed through the decoder: a code-tree header
// with the extreme symbol values, a symbol count, then payload bytes. The
// payload is first a short fixed table of bytes and then random bytes. The
// last bytes go past the count and act as padding. A software copy of the
// decoder predicts every output transfer. Sender gaps and receiver stalls run
// through several idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import hptd_pkg::*;

    localparam int TABLE_DEPTH = 255;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] MSG_COUNT = 32'd600;
    localparam logic [8:0] LEAF_FLAG = 9'h100;

    typedef struct {
        logic [7:0]  sym;
        logic [31:0] rep;
        logic        last;
        logic        done;
        logic        bad;
    } symbol_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // Decoder model state
    logic [1:0]  mdl_phase;
    logic [17:0] mdl_nodes [TABLE_DEPTH];
    logic [8:0]  mdl_stack [TABLE_DEPTH];
    int unsigned mdl_depth;
    int unsigned mdl_free;
    logic [8:0]  mdl_root;
    logic [7:0]  mdl_walk;
    logic [31:0] mdl_shift;
    int unsigned mdl_nbits;
    logic [31:0] mdl_left;

    symbol_out_t pending_symbols[$];
    logic [7:0]  stream_bytes[$];
    bit          header_bits[$];
    int          mismatches = 0;
    int          decoded = 0;
    int          sent = 0;
    int          cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    // Payload rows walked ahead of the random bytes
    logic [7:0]  payload_rows [12] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                                       8'h33, 8'hCC, 8'h01, 8'h80, 8'h7E, 8'h81};

    huffman_preorder_tree_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] stream_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] symbol, [39:8] repeat_count
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)     // [0] message_done, [1] malformed
    );

    always #4 clk = ~clk;

    // Hang a child under the open node on top of the stack, or make it the root
    function automatic bit hang_child(logic [8:0] child);
        logic [8:0] top;
        logic [7:0] idx;
        if (mdl_depth == 0)
        begin
            mdl_root = child;
            return child[8];
        end
        top = mdl_stack[mdl_depth - 1];
        idx = top[7:0];
        if (!top[8])
        begin
            mdl_nodes[idx][17:9] = child;
            mdl_stack[mdl_depth - 1] = top | LEAF_FLAG;
        end
        else
        begin
            mdl_nodes[idx][8:0] = child;
            mdl_depth--;
        end
        return (mdl_depth == 0) && child[8];
    endfunction

    function automatic void push_symbol(logic [7:0] s, logic [31:0] r, logic d, logic e);
        symbol_out_t o;
        o.sym = s; o.rep = r; o.last = 1'b0; o.done = d; o.bad = e;
        pending_symbols = {pending_symbols, o};
    endfunction

    // Advance the decoder model by one stream byte and queue its symbols
    function automatic void decode_byte(logic [7:0] data);
        int          n;
        logic        b;
        logic [8:0]  child;
        logic [17:0] entry;
        n = 0;
        for (int i = 7; i >= 0 && mdl_phase != PH_HALT; i--)
        begin
            b = data[i];
            if (mdl_phase == PH_TREE)
            begin
                if (mdl_nbits != 0)
                begin
                    mdl_shift = {24'd0, mdl_shift[6:0], b};
                    mdl_nbits--;
                    if (mdl_nbits == 0 && hang_child(LEAF_FLAG | mdl_shift[8:0]))
                    begin
                        mdl_phase = PH_COUNT;
                        mdl_shift = '0;
                    end
                end
                else if (b)
                begin
                    mdl_nbits = SYM_W;
                    mdl_shift = '0;
                end
                else if (mdl_free >= TABLE_DEPTH || mdl_depth >= TABLE_DEPTH)
                begin
                    push_symbol(8'd0, 32'd0, 1'b0, 1'b1);
                    n++;
                    mdl_phase = PH_HALT;
                end
                else
                begin
                    mdl_nodes[mdl_free] = '0;
                    void'(hang_child({1'b0, 8'(mdl_free)}));
                    mdl_stack[mdl_depth] = {1'b0, 8'(mdl_free)};
                    mdl_depth++;
                    mdl_free++;
                end
            end
            else if (mdl_phase == PH_COUNT)
            begin
                mdl_shift = {mdl_shift[30:0], b};
                mdl_nbits++;
                if (mdl_nbits >= COUNT_W)
                begin
                    mdl_left = mdl_shift;
                    mdl_shift = '0;
                    mdl_nbits = 0;
                    mdl_walk = '0;
                    if (mdl_left == 0)
                        mdl_phase = PH_HALT;
                    else if (mdl_root[8])
                    begin
                        push_symbol(mdl_root[7:0], mdl_left, 1'b1, 1'b0);
                        n++;
                        mdl_left = '0;
                        mdl_phase = PH_HALT;
                    end
                    else
                        mdl_phase = PH_PAYLOAD;
                end
            end
            else
            begin
                entry = mdl_nodes[mdl_walk];
                child = b ? entry[8:0] : entry[17:9];
                if (child[8])
                begin
                    mdl_left--;
                    mdl_walk = '0;
                    push_symbol(child[7:0], 32'd1, mdl_left == 0, 1'b0);
                    n++;
                    if (mdl_left == 0)
                        mdl_phase = PH_HALT;
                end
                else
                    mdl_walk = child[7:0];
            end
        end
        if (n > 0)
            pending_symbols[$].last = 1'b1;
    endfunction

    function automatic void add_leaf(logic [7:0] s);
        header_bits = {header_bits, 1'b1};
        for (int i = 7; i >= 0; i--)
            header_bits = {header_bits, s[i]};
    endfunction

    // Hold one byte on the slave side until it transfers
    task automatic send_byte(logic [7:0] data);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Drain the model queue before going on
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
    endtask

    // Predict on each slave transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            decode_byte(s_tdata);
    end

    // Compare each master transfer with the oldest prediction
    always @(posedge clk)
    begin
        symbol_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            decoded++;
            if (pending_symbols.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: sym=%h rep=%0d last=%b user=%b",
                             m_tdata[7:0], m_tdata[39:8], m_tlast, m_tuser);
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (m_tdata[7:0] !== want.sym || m_tdata[39:8] !== want.rep ||
                    m_tlast !== want.last || m_tuser[0] !== want.done ||
                    m_tuser[1] !== want.bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp sym=%h rep=%0d last=%b done=%b bad=%b",
                                 want.sym, want.rep, want.last, want.done, want.bad);
                        $display("          got sym=%h rep=%0d last=%b done=%b bad=%b",
                                 m_tdata[7:0], m_tdata[39:8], m_tlast, m_tuser[0],
                                 m_tuser[1]);
                    end
                end
            end
        end
    end

    // Randomize the master-side ready
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("huffman_preorder_tree_decoder test failed");
            $finish;
        end
    end

    initial
    begin
        int   rand_total;
        logic [7:0] acc;

        mdl_phase = PH_TREE;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            mdl_nodes[i] = '0;
            mdl_stack[i] = '0;
        end
        mdl_depth = 0; mdl_free = 0; mdl_root = '0; mdl_walk = '0;
        mdl_shift = '0; mdl_nbits = 0; mdl_left = '0;

        // Tree: ((00, FF), (A5, (5A, 01))), then the count
        header_bits = '{1'b0, 1'b0};
        add_leaf(8'h00);
        add_leaf(8'hFF);
        header_bits = {header_bits, 1'b0};
        add_leaf(8'hA5);
        header_bits = {header_bits, 1'b0};
        add_leaf(8'h5A);
        add_leaf(8'h01);
        for (int i = 31; i >= 0; i--)
            header_bits = {header_bits, MSG_COUNT[i]};

        // Pack header bits MSB first; the tail byte carries payload bits too
        acc = '0;
        for (int i = 0; i < header_bits.size(); i++)
        begin
            acc = {acc[6:0], header_bits[i]};
            if (i % 8 == 7)
                stream_bytes = {stream_bytes, acc};
        end
        if (header_bits.size() % 8 != 0)
            stream_bytes = {stream_bytes, acc << (8 - header_bits.size() % 8)};
        foreach (payload_rows[i])
            stream_bytes = {stream_bytes, payload_rows[i]};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Header and fixed payload rows, no idling
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i]);
        wait_drained();

        // Random payload through the idling phases
        rand_total = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 81; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 81; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            repeat (45)
            begin
                send_byte(8'($urandom));
                rand_total++;
            end
            if (ph == 1)
                wait_drained();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Wait out the tail
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("streamed %0d bytes (%0d random), %0d symbols checked, message %s",
                 sent, rand_total, decoded,
                 (mdl_phase == PH_HALT) ? "completed with padding" : "still open");
        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("huffman_preorder_tree_decoder test passed");
        else
            $display("huffman_preorder_tree_decoder test failed");
        $finish;
    end

endmodule
